// ===== rtl/core/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants
// Command codes, status codes, stack geometry and controller/datapath structs.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DIV_W       = DATA_W + FRAC_BITS;

    localparam logic [3:0] CMD_PUSH    = 4'd0;
    localparam logic [3:0] CMD_ADD     = 4'd1;
    localparam logic [3:0] CMD_SUB     = 4'd2;
    localparam logic [3:0] CMD_MUL     = 4'd3;
    localparam logic [3:0] CMD_DIV     = 4'd4;
    localparam logic [3:0] CMD_MOD     = 4'd5;
    localparam logic [3:0] CMD_PEEK    = 4'd6;
    localparam logic [3:0] CMD_DUP     = 4'd7;
    localparam logic [3:0] CMD_SWAP    = 4'd8;
    localparam logic [3:0] CMD_CLEAR   = 4'd9;
    localparam logic [3:0] CMD_POPSHOW = 4'd10;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_ZDIV  = 3'd3;
    localparam logic [2:0] ST_SWAP  = 3'd4;

    // datapath register loads
    localparam logic [1:0] LD_NONE = 2'd0;
    localparam logic [1:0] LD_B    = 2'd1;
    localparam logic [1:0] LD_A    = 2'd2;

    // result selects for write data
    localparam logic [2:0] WR_OPV = 3'd0;
    localparam logic [2:0] WR_ALU = 3'd1;
    localparam logic [2:0] WR_A   = 3'd2;
    localparam logic [2:0] WR_B   = 3'd3;
    localparam logic [2:0] WR_DIV = 3'd4;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [2:0]        wr_sel;
        logic [1:0]        ld;
        logic              alu_go;
        logic              div_go;
        logic              top_clr;
        logic              top_ld;
        logic              sec_clr;
        logic              sec_ld;
        logic [2:0]        top_sel;
    } rpn_cmd_t;

    typedef struct packed {
        logic              div_done;
        logic              b_zero;
    } rpn_stat_t;

endpackage

// ===== rtl/core/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/rpn_div.sv =====
// ----------------------------------------------------------------------------
// rpn_div: iterative signed divider
// Restoring division, one quotient bit per cycle. Gives the saturated
// fixed-point quotient (a << FRAC_BITS) / b and the remainder a % b.
// ----------------------------------------------------------------------------
module rpn_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        is_mod,
    input  logic [rpn_pkg::DATA_W-1:0]  a,
    input  logic [rpn_pkg::DATA_W-1:0]  b,
    output logic                        done,
    output logic [rpn_pkg::DATA_W-1:0]  result
);

    localparam int W  = rpn_pkg::DIV_W;
    localparam int DW = rpn_pkg::DATA_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  num_reg, num_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          qneg_reg, rneg_reg, mod_reg, done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] abs_a, abs_b;
    logic [W-1:0]  qmag;
    logic [DW-1:0] rmag;
    logic [W:0]    qs;

    assign abs_a = a[DW-1] ? (~a + 1'b1) : a;
    assign abs_b = b[DW-1] ? (~b + 1'b1) : b;

    assign trial = {rem_reg[DW-1:0], num_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            num_next  = is_mod ? W'(abs_a) : {abs_a, {rpn_pkg::FRAC_BITS{1'b0}}};
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_next = diff;
                num_next = {num_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                num_next = {num_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= busy_reg && (cnt_reg == CW'(1));
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg  <= abs_b;
            qneg_reg <= a[DW-1] ^ b[DW-1];
            rneg_reg <= a[DW-1];
            mod_reg  <= is_mod;
        end
    end

    assign qmag = num_reg;
    assign rmag = rem_reg[DW-1:0];
    assign qs   = qneg_reg ? (~{1'b0, qmag} + 1'b1) : {1'b0, qmag};

    always_comb begin
        if (mod_reg) begin
            result = rneg_reg ? (~rmag + 1'b1) : rmag;
        end else if (!qneg_reg && (qmag > W'({1'b0, {(DW-1){1'b1}}}))) begin
            result = {1'b0, {(DW-1){1'b1}}};
        end else if (qneg_reg && (qmag > W'({1'b1, {(DW-1){1'b0}}}))) begin
            result = {1'b1, {(DW-1){1'b0}}};
        end else begin
            result = qs[DW-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/core/rpn_datapath.sv =====
// ----------------------------------------------------------------------------
// rpn_datapath: stack memory, operand registers, ALU and divider
// Holds the stack RAM, the two operand registers, the saturating
// add/sub/mul unit and the divider, plus the result registers.
// ----------------------------------------------------------------------------
module rpn_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rpn_pkg::rpn_cmd_t          ctl,
    input  logic [3:0]                 cmd,
    input  logic [rpn_pkg::DATA_W-1:0] opv,
    output rpn_pkg::rpn_stat_t         stat,
    output logic [rpn_pkg::DATA_W-1:0] top_value,
    output logic [rpn_pkg::DATA_W-1:0] second_value
);

    localparam int DW = rpn_pkg::DATA_W;
    localparam int FB = rpn_pkg::FRAC_BITS;

    logic [DW-1:0] rd_data, wr_data;
    logic [DW-1:0] a_reg, b_reg, alu_reg, top_reg, sec_reg;
    logic [DW-1:0] alu_next, div_res;
    logic [DW:0]   sum;
    logic signed [2*DW-1:0] prod_reg;
    logic signed [2*DW-1:0] prod_sh;
    logic          mul_pend_reg;
    logic          div_done;

    rpn_ram #(.WIDTH(DW), .DEPTH(rpn_pkg::STACK_DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (ctl.wr_en),
        .wr_addr (ctl.wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_addr),
        .rd_data (rd_data)
    );

    rpn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.div_go),
        .is_mod  (cmd == rpn_pkg::CMD_MOD),
        .a       (a_reg),
        .b       (b_reg),
        .done    (div_done),
        .result  (div_res)
    );

    assign prod_sh = prod_reg >>> FB;

    always_comb begin
        if (cmd == rpn_pkg::CMD_SUB) begin
            sum = {a_reg[DW-1], a_reg} - {b_reg[DW-1], b_reg};
        end else begin
            sum = {a_reg[DW-1], a_reg} + {b_reg[DW-1], b_reg};
        end
        if (mul_pend_reg) begin
            if (prod_sh > $signed({{(DW+1){1'b0}}, {(DW-1){1'b1}}})) begin
                alu_next = {1'b0, {(DW-1){1'b1}}};
            end else if (prod_sh < $signed({{(DW+1){1'b1}}, {(DW-1){1'b0}}})) begin
                alu_next = {1'b1, {(DW-1){1'b0}}};
            end else begin
                alu_next = prod_sh[DW-1:0];
            end
        end else if (sum[DW] != sum[DW-1]) begin
            alu_next = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            alu_next = sum[DW-1:0];
        end
    end

    always_comb begin
        unique case (ctl.wr_sel)
            rpn_pkg::WR_OPV: wr_data = opv;
            rpn_pkg::WR_ALU: wr_data = alu_reg;
            rpn_pkg::WR_A:   wr_data = a_reg;
            rpn_pkg::WR_B:   wr_data = b_reg;
            rpn_pkg::WR_DIV: wr_data = div_res;
            default:         wr_data = opv;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_pend_reg <= 1'b0;
        end else begin
            mul_pend_reg <= ctl.alu_go && (cmd == rpn_pkg::CMD_MUL);
        end
        if (ctl.ld == rpn_pkg::LD_B) begin
            b_reg <= rd_data;
        end
        if (ctl.ld == rpn_pkg::LD_A) begin
            a_reg <= rd_data;
        end
        if (ctl.alu_go) begin
            prod_reg <= $signed(a_reg) * $signed(b_reg);
        end
        alu_reg <= alu_next;
        if (ctl.top_clr) begin
            top_reg <= '0;
        end else if (ctl.top_ld) begin
            top_reg <= (ctl.top_sel == rpn_pkg::WR_B) ? b_reg : rd_data;
        end
        if (ctl.sec_clr) begin
            sec_reg <= '0;
        end else if (ctl.sec_ld) begin
            sec_reg <= rd_data;
        end
    end

    assign stat.div_done = div_done;
    assign stat.b_zero   = (b_reg == '0);
    assign top_value     = top_reg;
    assign second_value  = sec_reg;

endmodule

// ===== rtl/core/rpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpn_ctrl: command sequencer
// Accepts a command, steps the stack pointer and datapath through
// reads, arithmetic and writes, then presents the result item.
// ----------------------------------------------------------------------------
module rpn_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [3:0]                 s_cmd,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [3:0]                 cmd,
    output rpn_pkg::rpn_cmd_t          ctl,
    input  rpn_pkg::rpn_stat_t         stat,
    output logic [2:0]                 status,
    output logic [7:0]                 stack_count
);

    localparam int AW = rpn_pkg::ADDR_W;
    localparam int CW = rpn_pkg::CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDB   = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_LDA   = 4'd3;
    localparam logic [3:0] S_ALU   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_WR    = 4'd7;
    localparam logic [3:0] S_SHOW  = 4'd8;
    localparam logic [3:0] S_SHOW2 = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_SWP   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [2:0]    st_reg, st_next;
    logic [3:0]    cmd_reg, cmd_next;
    logic          two_reg, two_next;
    logic [CW-1:0] sp_m1, sp_m2;

    assign sp_m1 = sp_reg - 1'b1;
    assign sp_m2 = sp_reg - 2'd2;

    always_comb begin
        state_next = state_reg;
        sp_next    = sp_reg;
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        two_next   = two_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = s_cmd;
                    st_next  = rpn_pkg::ST_OK;
                    two_next = 1'b0;
                    ctl.top_clr = 1'b1;
                    ctl.sec_clr = 1'b1;
                    state_next  = S_SHOW;
                    unique case (s_cmd) inside
                        rpn_pkg::CMD_PUSH: begin
                            if (sp_reg == CW'(rpn_pkg::STACK_DEPTH)) begin
                                st_next = rpn_pkg::ST_FULL;
                            end else begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_addr = sp_reg[AW-1:0];
                                ctl.wr_sel  = rpn_pkg::WR_OPV;
                                sp_next     = sp_reg + 1'b1;
                            end
                        end
                        rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
                        rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
                            if (sp_reg == '0) begin
                                st_next = rpn_pkg::ST_EMPTY;
                            end else begin
                                ctl.rd_en   = 1'b1;
                                ctl.rd_addr = sp_m1[AW-1:0];
                                sp_next     = sp_m1;
                                state_next  = S_RDB;
                            end
                        end
                        rpn_pkg::CMD_PEEK: begin
                            two_next = 1'b1;
                            if (sp_reg < CW'(2)) begin
                                st_next = rpn_pkg::ST_EMPTY;
                            end
                        end
                        rpn_pkg::CMD_DUP: begin
                            two_next = 1'b1;
                            if (sp_reg == '0) begin
                                st_next = rpn_pkg::ST_EMPTY;
                            end else if (sp_reg == CW'(rpn_pkg::STACK_DEPTH)) begin
                                st_next = rpn_pkg::ST_FULL;
                            end else begin
                                ctl.rd_en   = 1'b1;
                                ctl.rd_addr = sp_m1[AW-1:0];
                                state_next  = S_RDB;
                            end
                        end
                        rpn_pkg::CMD_SWAP: begin
                            two_next = 1'b1;
                            if (sp_reg < CW'(2)) begin
                                st_next = rpn_pkg::ST_SWAP;
                            end else begin
                                ctl.rd_en   = 1'b1;
                                ctl.rd_addr = sp_m1[AW-1:0];
                                state_next  = S_RDB;
                            end
                        end
                        rpn_pkg::CMD_CLEAR: begin
                            sp_next = '0;
                        end
                        rpn_pkg::CMD_POPSHOW: begin
                            if (sp_reg == '0) begin
                                st_next    = rpn_pkg::ST_EMPTY;
                                state_next = S_OUT;
                            end else begin
                                ctl.rd_en   = 1'b1;
                                ctl.rd_addr = sp_m1[AW-1:0];
                                sp_next     = sp_m1;
                                state_next  = S_RDB;
                            end
                        end
                        default: state_next = S_SHOW;
                    endcase
                end
            end
            S_RDB: begin
                ctl.ld = rpn_pkg::LD_B;
                if (cmd_reg == rpn_pkg::CMD_POPSHOW) begin
                    state_next = S_OUT;
                end else if (cmd_reg == rpn_pkg::CMD_DUP) begin
                    state_next = S_WR;
                end else if (cmd_reg == rpn_pkg::CMD_SWAP) begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = sp_m2[AW-1:0];
                    state_next  = S_RDA;
                end else begin
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                if (cmd_reg == rpn_pkg::CMD_SWAP) begin
                    ctl.ld      = rpn_pkg::LD_A;
                    ctl.wr_en   = 1'b1;
                    ctl.wr_addr = sp_m2[AW-1:0];
                    ctl.wr_sel  = rpn_pkg::WR_B;
                    state_next  = S_SWP;
                end else if ((cmd_reg == rpn_pkg::CMD_DIV || cmd_reg == rpn_pkg::CMD_MOD)
                             && stat.b_zero) begin
                    st_next    = rpn_pkg::ST_ZDIV;
                    state_next = S_SHOW;
                end else if (sp_reg == '0) begin
                    st_next    = rpn_pkg::ST_EMPTY;
                    state_next = S_SHOW;
                end else begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = sp_m1[AW-1:0];
                    sp_next     = sp_m1;
                    state_next  = S_LDA;
                end
            end
            S_LDA: begin
                ctl.ld = rpn_pkg::LD_A;
                state_next = S_ALU;
            end
            S_ALU: begin
                if (cmd_reg == rpn_pkg::CMD_DIV || cmd_reg == rpn_pkg::CMD_MOD) begin
                    ctl.div_go = 1'b1;
                    state_next = S_DIV;
                end else begin
                    ctl.alu_go = 1'b1;
                    state_next = (cmd_reg == rpn_pkg::CMD_MUL) ? S_MUL : S_WR;
                end
            end
            S_MUL: begin
                state_next = S_WR;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_addr = sp_reg[AW-1:0];
                    ctl.wr_sel  = rpn_pkg::WR_DIV;
                    sp_next     = sp_reg + 1'b1;
                    state_next  = S_SHOW;
                end
            end
            S_WR: begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = sp_reg[AW-1:0];
                ctl.wr_sel  = (cmd_reg == rpn_pkg::CMD_DUP) ? rpn_pkg::WR_B
                                                            : rpn_pkg::WR_ALU;
                sp_next     = sp_reg + 1'b1;
                state_next  = S_SHOW;
            end
            S_SWP: begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = sp_m1[AW-1:0];
                ctl.wr_sel  = rpn_pkg::WR_A;
                state_next  = S_SHOW;
            end
            S_SHOW: begin
                ctl.rd_en   = (sp_reg != '0);
                ctl.rd_addr = sp_m1[AW-1:0];
                state_next  = S_SHOW2;
            end
            S_SHOW2: begin
                ctl.top_ld  = (sp_reg != '0);
                ctl.top_sel = rpn_pkg::WR_OPV;
                if (two_reg && sp_reg >= CW'(2)) begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_addr = sp_m2[AW-1:0];
                    state_next  = S_OUT;
                end else begin
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                if (two_reg && sp_reg >= CW'(2) && !m_tvalid) begin
                    ctl.sec_ld = 1'b1;
                end
                if (cmd_reg == rpn_pkg::CMD_POPSHOW && st_reg == rpn_pkg::ST_OK
                    && !m_tvalid) begin
                    ctl.top_ld  = 1'b1;
                    ctl.top_sel = rpn_pkg::WR_B;
                end
                if (m_tvalid && m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic out_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            st_reg    <= rpn_pkg::ST_OK;
            cmd_reg   <= rpn_pkg::CMD_PUSH;
            two_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            st_reg    <= st_next;
            cmd_reg   <= cmd_next;
            two_reg   <= two_next;
            out_v_reg <= (state_reg == S_OUT) && !(out_v_reg && m_tready);
        end
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = out_v_reg;
    assign cmd         = cmd_reg;
    assign status      = st_reg;
    assign stack_count = 8'(sp_reg);

endmodule

// ===== rtl/core/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator: reverse Polish Q16.16 stack evaluator
// Channel  Dir  tdata fields (low to high)
// s_axis   in   cmd[3:0], operand_value[35:4]
// m_axis   out  top_value[31:0], second_value[63:32], status[66:64],
//               stack_count[74:67]
// One item at a time. Div/mod runs the divider, which gives one quotient bit per
// cycle over 48 bits.
// Result waits in the output register until m_tready; no new item meanwhile.
// aresetn is synchronous and empties the stack; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[3:0], operand_value[35:4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // top_value, second_value, status, stack_count
);

    rpn_pkg::rpn_cmd_t  ctl;
    rpn_pkg::rpn_stat_t stat;
    logic [3:0]  cmd;
    logic [2:0]  status;
    logic [7:0]  stack_count;
    logic [31:0] top_value, second_value;

    rpn_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_cmd       (s_tdata[3:0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .ctl         (ctl),
        .stat        (stat),
        .status      (status),
        .stack_count (stack_count)
    );

    rpn_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .cmd          (cmd),
        .opv          (s_tdata[35:4]),
        .stat         (stat),
        .top_value    (top_value),
        .second_value (second_value)
    );

    assign m_tdata = {5'd0, stack_count, status, second_value, top_value};

endmodule

// ===== dv/rpn_stack_calculator_tb.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator_tb: self-checking bench for the RPN stack calculator
// Random and directed command streams with idle gaps on both sides; a local
// Q16.16 stack model predicts each result item and the monitor compares it.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_tb;

    typedef struct packed {
        logic [7:0]  count;
        logic [2:0]  status;
        logic [31:0] second;
        logic [31:0] top;
    } calc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    logic [39:0]  cmd_queue[$];
    calc_result_t expected_results[$];
    logic [31:0]  model_stack[rpn_pkg::STACK_DEPTH];
    int           model_depth = 0;
    int           error_count = 0;
    int           idle_cycles = 0;
    int           hold_cycles = 0;
    bit           sender_paused = 1'b0;
    bit           sink_blocked = 1'b0;

    rpn_stack_calculator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [31:0] saturate(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic calc_result_t predict_result(logic [3:0] cmd, logic [31:0] opv);
        calc_result_t r;
        logic [31:0] a, b, t;
        longint sa, sb, p, q;
        bit show_two, popped;
        r = '0;
        show_two = 1'b0;
        popped = 1'b0;
        case (cmd)
            rpn_pkg::CMD_PUSH: begin
                if (model_depth >= rpn_pkg::STACK_DEPTH) r.status = rpn_pkg::ST_FULL;
                else model_stack[model_depth++] = opv;
            end
            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL: begin
                if (model_depth < 2) begin
                    model_depth = 0;
                    r.status = rpn_pkg::ST_EMPTY;
                end else begin
                    b = model_stack[--model_depth];
                    a = model_stack[--model_depth];
                    sa = longint'($signed(a));
                    sb = longint'($signed(b));
                    if (cmd == rpn_pkg::CMD_ADD) p = sa + sb;
                    else if (cmd == rpn_pkg::CMD_SUB) p = sa - sb;
                    else p = (sa * sb) >>> rpn_pkg::FRAC_BITS;
                    model_stack[model_depth++] = saturate(p);
                end
            end
            rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
                if (model_depth == 0) r.status = rpn_pkg::ST_EMPTY;
                else begin
                    b = model_stack[--model_depth];
                    if (b == 0) r.status = rpn_pkg::ST_ZDIV;
                    else if (model_depth == 0) r.status = rpn_pkg::ST_EMPTY;
                    else begin
                        a = model_stack[--model_depth];
                        sa = longint'($signed(a));
                        sb = longint'($signed(b));
                        if (cmd == rpn_pkg::CMD_DIV)
                            q = (sa * (64'sd1 << rpn_pkg::FRAC_BITS)) / sb;
                        else q = sa % sb;
                        model_stack[model_depth++] = saturate(q);
                    end
                end
            end
            rpn_pkg::CMD_PEEK: begin
                show_two = 1'b1;
                if (model_depth < 2) r.status = rpn_pkg::ST_EMPTY;
            end
            rpn_pkg::CMD_DUP: begin
                show_two = 1'b1;
                if (model_depth == 0) r.status = rpn_pkg::ST_EMPTY;
                else if (model_depth >= rpn_pkg::STACK_DEPTH) r.status = rpn_pkg::ST_FULL;
                else begin
                    model_stack[model_depth] = model_stack[model_depth-1];
                    model_depth++;
                end
            end
            rpn_pkg::CMD_SWAP: begin
                show_two = 1'b1;
                if (model_depth >= 2) begin
                    t = model_stack[model_depth-1];
                    model_stack[model_depth-1] = model_stack[model_depth-2];
                    model_stack[model_depth-2] = t;
                end else r.status = rpn_pkg::ST_SWAP;
            end
            rpn_pkg::CMD_CLEAR: model_depth = 0;
            rpn_pkg::CMD_POPSHOW: begin
                popped = 1'b1;
                if (model_depth == 0) r.status = rpn_pkg::ST_EMPTY;
                else r.top = model_stack[--model_depth];
            end
            default: ;
        endcase
        if (!popped && model_depth >= 1) r.top = model_stack[model_depth-1];
        if (show_two && model_depth >= 2) r.second = model_stack[model_depth-2];
        r.count = 8'(model_depth);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic add_item(logic [3:0] cmd, logic [31:0] opv);
        cmd_queue.push_back({opv, cmd});
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4: return 32'($signed($urandom_range(0, 2000)) - 1000);
            5: return {{12{1'b0}}, 20'($urandom)} ^ ($urandom_range(0, 1) ? '1 : '0);
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (cmd_queue.size() > 0 && !sender_paused && $urandom_range(0, 3) != 0) begin
                s_tdata  <= cmd_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(predict_result(s_tdata[3:0], s_tdata[35:4]));
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (sink_blocked) begin
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 99))
                0:       hold_cycles <= $urandom_range(50, 300);
                1, 2, 3: hold_cycles <= $urandom_range(2, 12);
                default: ;
            endcase
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        calc_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[74:0];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result item", got.top, 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (got.top != want.top) report_mismatch("top_value", got.top, want.top);
                if (got.second != want.second)
                    report_mismatch("second_value", got.second, want.second);
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.count != want.count)
                    report_mismatch("stack_count", 32'(got.count), 32'(want.count));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int n, kind;
        logic [3:0] c;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: edges, every command, the empty, zero-divide and swap error paths
        add_item(rpn_pkg::CMD_POPSHOW, '0);
        add_item(rpn_pkg::CMD_ADD, '0);
        add_item(rpn_pkg::CMD_DUP, '0);
        add_item(rpn_pkg::CMD_SWAP, '0);
        add_item(rpn_pkg::CMD_PEEK, '0);
        add_item(rpn_pkg::CMD_PUSH, 32'h7fffffff);
        add_item(rpn_pkg::CMD_PEEK, '0);
        add_item(rpn_pkg::CMD_DUP, '0);
        add_item(rpn_pkg::CMD_ADD, '0);
        add_item(rpn_pkg::CMD_PUSH, 32'h80000000);
        add_item(rpn_pkg::CMD_PUSH, 32'h80000000);
        add_item(rpn_pkg::CMD_MUL, '0);
        add_item(rpn_pkg::CMD_PUSH, 32'hffff8000);
        add_item(rpn_pkg::CMD_SWAP, '0);
        add_item(rpn_pkg::CMD_SUB, '0);
        add_item(rpn_pkg::CMD_PUSH, '0);
        add_item(rpn_pkg::CMD_DIV, '0);
        add_item(rpn_pkg::CMD_PUSH, 32'h00000003);
        add_item(rpn_pkg::CMD_MOD, '0);
        add_item(rpn_pkg::CMD_PUSH, 32'hfffffffd);
        add_item(rpn_pkg::CMD_DIV, '0);
        add_item(rpn_pkg::CMD_DIV, '0);
        add_item(4'd15, 32'hffffffff);
        add_item(4'd11, '0);
        add_item(rpn_pkg::CMD_CLEAR, '0);

        // fill to full, overflow push and dup, then six multiplies on the full stack
        for (int i = 0; i < rpn_pkg::STACK_DEPTH + 2; i++)
            add_item(rpn_pkg::CMD_PUSH, rand_value());
        add_item(rpn_pkg::CMD_DUP, '0);
        for (int i = 0; i < 6; i++) add_item(rpn_pkg::CMD_MUL, '0);

        // long receiver hold-off while the sender keeps offering
        sink_blocked = 1'b1;
        repeat (400) @(posedge aclk);
        sink_blocked = 1'b0;

        n = 0;
        while (n < 790) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // expression-like run: push one to four values, then one to four commands
                repeat ($urandom_range(1, 4)) begin
                    add_item(rpn_pkg::CMD_PUSH, rand_value());
                    n++;
                end
                repeat ($urandom_range(1, 4)) begin
                    c = 4'($urandom_range(rpn_pkg::CMD_ADD, rpn_pkg::CMD_POPSHOW));
                    if (c == rpn_pkg::CMD_CLEAR && $urandom_range(0, 3) != 0)
                        c = rpn_pkg::CMD_ADD;
                    add_item(c, $urandom);
                    n++;
                end
            end else begin
                add_item(4'($urandom_range(0, 15)), $urandom);
                n++;
            end
            if (n > 350 && n < 360) begin
                // sender pauses until all results are back
                while (cmd_queue.size() > 0) @(posedge aclk);
                sender_paused = 1'b1;
                while (s_tvalid || expected_results.size() > 0) @(posedge aclk);
                sender_paused = 1'b0;
                n = 360;
            end
        end
        while (cmd_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
